// File: hdl/zsbi_pkg.sv
// Shared types, constants and helpers for the zlib stored-block inflater.
// No dependencies; imported by zsbi_adler, zlib_stored_block_inflater and tb_top.
`default_nettype none

package zsbi_pkg;

    localparam int unsigned IN_W      = 8;
    localparam int unsigned OUT_W     = 16;
    localparam int unsigned STATUS_W  = 4;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    localparam logic [3:0] CM_DEFLATE  = 4'h8;
    localparam logic [3:0] CINFO_MAX   = 4'h7;
    localparam int unsigned FDICT_BIT  = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 4'd0,
        ST_DONE      = 4'd1,
        ST_METHOD    = 4'd2,
        ST_WINDOW    = 4'd3,
        ST_FCHECK    = 4'd4,
        ST_DICT      = 4'd5,
        ST_BTYPE     = 4'd6,
        ST_NLEN      = 4'd7,
        ST_CHECKSUM  = 4'd8,
        ST_AFTER_END = 4'd9,
        ST_RESERVED  = 4'd10
    } status_t;

    typedef struct packed {
        logic       init;
        logic       add;
        logic [7:0] data;
    } adler_ctl_t;

    // 2^5 == 1 mod 31: fold 5-bit digits, then the residue is 0 iff sum is 0 or 31
    function automatic logic mult_of_31(input logic [15:0] w);
        logic [6:0] s1;
        logic [5:0] s2;
        s1 = 7'(w[4:0]) + 7'(w[9:5]) + 7'(w[14:10]) + 7'(w[15]);
        s2 = 6'(s1[4:0]) + 6'(s1[6:5]);
        return (s2 == 6'd0) || (s2 == 6'd31);
    endfunction

endpackage

`default_nettype wire

// File: hdl/zsbi_adler.sv
// Adler-32 accumulator: one byte per cycle while ctl.add is set, modulo 65521 by conditional subtract.
// Depends on zsbi_pkg.
`default_nettype none

module zsbi_adler (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire zsbi_pkg::adler_ctl_t ctl,
    output logic [31:0]               sum
);
    import zsbi_pkg::*;

    logic [15:0] sum_low_reg,  sum_low_next;
    logic [15:0] sum_high_reg, sum_high_next;
    logic [16:0] a_raw, h_raw;
    logic [15:0] a_mod;

    always_comb begin
        a_raw = 17'(sum_low_reg) + 17'(ctl.data);
        a_mod = (a_raw >= ADLER_MOD) ? 16'(a_raw - ADLER_MOD) : a_raw[15:0];
        h_raw = 17'(sum_high_reg) + 17'(a_mod);
        sum_low_next  = sum_low_reg;
        sum_high_next = sum_high_reg;
        if (ctl.init) begin
            sum_low_next  = 16'd1;
            sum_high_next = 16'd0;
        end else if (ctl.add) begin
            sum_low_next  = a_mod;
            sum_high_next = (h_raw >= ADLER_MOD) ? 16'(h_raw - ADLER_MOD) : h_raw[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_low_reg  <= 16'd1;
            sum_high_reg <= 16'd0;
        end else begin
            sum_low_reg  <= sum_low_next;
            sum_high_reg <= sum_high_next;
        end
    end

    assign sum = {sum_high_reg, sum_low_reg};

    a_low_range: assert property (@(posedge aclk) disable iff (!aresetn)
        17'(sum_low_reg) < ADLER_MOD)
        else $error("adler low half out of range");

    a_high_range: assert property (@(posedge aclk) disable iff (!aresetn)
        17'(sum_high_reg) < ADLER_MOD)
        else $error("adler high half out of range");

    a_init: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.init |=> (sum_low_reg == 16'd1) && (sum_high_reg == 16'd0))
        else $error("adler init not applied");

endmodule

`default_nettype wire

// File: hdl/zlib_stored_block_inflater.sv
// zlib stored-block inflater: parses header, stored blocks and Adler-32 trailer.
// One result word per input word, loaded into the result register on acceptance.
// Throughput: one byte per cycle; s_tready drops only while the result register is full
// and not being taken. Reset (aresetn low, synchronous) returns the parser to the first
// header byte, empties the result register and sets Adler-32 to its start value.
// Depends on zsbi_pkg and zsbi_adler.
`default_nettype none

module zlib_stored_block_inflater (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [zsbi_pkg::IN_W-1:0]   s_tdata,   // [7:0] in_byte
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [zsbi_pkg::OUT_W-1:0]       m_tdata    // [0] data_valid, [8:1] data_byte,
                                                        // [12:9] status, [15:13] zero
);
    import zsbi_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_BLKHDR  = 3'd2,
        PH_LEN     = 3'd3,
        PH_DATA    = 3'd4,
        PH_TRAILER = 3'd5,
        PH_END     = 3'd6
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [1:0]  idx_reg,      idx_next;
    logic [7:0]  cmf_reg,      cmf_next;
    logic        final_reg,    final_next;
    logic [15:0] blen_reg,     blen_next;
    logic [7:0]  nlen_lo_reg,  nlen_lo_next;
    logic [15:0] copied_reg,   copied_next;
    logic [31:0] expect_reg,   expect_next;
    logic        m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic        accept;
    logic [7:0]  b;
    logic        dv;
    logic [7:0]  db;
    status_t     st;
    logic [31:0] acc;
    logic [15:0] nlen;
    logic [15:0] copied_inc;
    logic [31:0] adler_sum;
    adler_ctl_t  actl;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign acc      = {expect_reg[23:0], b};
    assign nlen     = {b, nlen_lo_reg};
    assign copied_inc = copied_reg + 16'd1;

    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        cmf_next     = cmf_reg;
        final_next   = final_reg;
        blen_next    = blen_reg;
        nlen_lo_next = nlen_lo_reg;
        copied_next  = copied_reg;
        expect_next  = expect_reg;
        dv           = 1'b0;
        db           = 8'd0;
        st           = ST_OK;
        actl.init    = 1'b0;
        actl.add     = 1'b0;
        actl.data    = b;
        unique case (phase_reg)
            PH_HDR1: begin
                if (b[3:0] != CM_DEFLATE) begin
                    st = ST_METHOD;
                end else if (b[7:4] > CINFO_MAX) begin
                    st = ST_WINDOW;
                end else begin
                    cmf_next   = b;
                    actl.init  = 1'b1;
                    phase_next = PH_HDR2;
                end
            end
            PH_HDR2: begin
                if (!mult_of_31({cmf_reg, b})) begin
                    st = ST_FCHECK;
                end else if (b[FDICT_BIT]) begin
                    st = ST_DICT;
                end else begin
                    phase_next = PH_BLKHDR;
                end
            end
            PH_BLKHDR: begin
                if (b[2:1] != 2'b00) begin
                    st = ST_BTYPE;
                end else begin
                    final_next   = b[0];
                    idx_next     = 2'd0;
                    blen_next    = 16'd0;
                    nlen_lo_next = 8'd0;
                    copied_next  = 16'd0;
                    phase_next   = PH_LEN;
                end
            end
            PH_LEN: begin
                unique case (idx_reg)
                    2'd0: begin
                        blen_next = {8'd0, b};
                        idx_next  = 2'd1;
                    end
                    2'd1: begin
                        blen_next = {b, blen_reg[7:0]};
                        idx_next  = 2'd2;
                    end
                    2'd2: begin
                        nlen_lo_next = b;
                        idx_next     = 2'd3;
                    end
                    default: begin
                        if (~nlen != blen_reg) begin
                            st = ST_NLEN;
                        end else begin
                            idx_next    = 2'd0;
                            copied_next = 16'd0;
                            if (blen_reg == 16'd0) begin
                                phase_next  = final_reg ? PH_TRAILER : PH_BLKHDR;
                                expect_next = 32'd0;
                            end else begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                endcase
            end
            PH_DATA: begin
                dv          = 1'b1;
                db          = b;
                actl.add    = 1'b1;
                copied_next = copied_inc;
                if (copied_inc >= blen_reg) begin
                    phase_next  = final_reg ? PH_TRAILER : PH_BLKHDR;
                    idx_next    = 2'd0;
                    expect_next = 32'd0;
                end
            end
            PH_TRAILER: begin
                if (idx_reg != 2'd3) begin
                    expect_next = acc;
                    idx_next    = idx_reg + 2'd1;
                end else if (acc != adler_sum) begin
                    st = ST_CHECKSUM;
                end else begin
                    expect_next = acc;
                    phase_next  = PH_END;
                    st          = ST_DONE;
                end
            end
            default: begin
                st = ST_AFTER_END;
            end
        endcase
        if (!accept) begin
            actl.init = 1'b0;
            actl.add  = 1'b0;
        end
    end

    zsbi_adler u_adler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (actl),
        .sum     (adler_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR1;
            idx_reg      <= 2'd0;
            cmf_reg      <= 8'd0;
            final_reg    <= 1'b0;
            blen_reg     <= 16'd0;
            nlen_lo_reg  <= 8'd0;
            copied_reg   <= 16'd0;
            expect_reg   <= 32'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                idx_reg     <= idx_next;
                cmf_reg     <= cmf_next;
                final_reg   <= final_next;
                blen_reg    <= blen_next;
                nlen_lo_reg <= nlen_lo_next;
                copied_reg  <= copied_next;
                expect_reg  <= expect_next;
                m_tdata_reg <= {3'd0, st, db, dv};
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[12:9] == ST_OK)
        else $error("data word carries non-ok status");

    a_data_len: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> copied_reg < blen_reg)
        else $error("data phase with no bytes left");

    a_end_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_END |-> expect_reg == adler_sum)
        else $error("ended with mismatched checksum");

    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(phase_reg) && $stable(copied_reg))
        else $error("parser state moved without an input word");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for zlib_stored_block_inflater: sends one zlib stream of stored blocks with
// header, block-type, NLEN and checksum errors mixed in, and checks each result word.
// Depends on zsbi_pkg and the inflater RTL.

module tb_top;
    import zsbi_pkg::*;

    typedef enum logic [2:0] {
        PH_CMF, PH_FLG, PH_BLKHDR, PH_LEN, PH_DATA, PH_TRAILER, PH_END
    } phase_t;

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        status_t    status;
    } inflate_word_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;   // [7:0] in_byte
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // [0] data_valid, [8:1] data_byte, [12:9] status

    logic [7:0]    stream_bytes[$];
    inflate_word_t inflated_words[$];
    int unsigned   cycle_count    = 0;
    int unsigned   mismatch_count = 0;
    logic          calm;

    // inflater state as predicted
    phase_t      ph         = PH_CMF;
    logic [1:0]  field_idx  = '0;
    logic [7:0]  cmf_byte   = '0;
    logic        last_block = 1'b0;
    logic [15:0] blk_len    = '0;
    logic [7:0]  nlen_low   = '0;
    logic [15:0] copied     = '0;
    logic [31:0] adler      = 32'd1;
    logic [31:0] trailer    = '0;

    // running Adler-32 of the stream being built
    logic [31:0] gen_adler = 32'd1;

    assign calm = (cycle_count >= 1200) && (cycle_count < 2000);

    zlib_stored_block_inflater u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [31:0] adler_next(input logic [31:0] s, input logic [7:0] b);
        logic [16:0] lo;
        logic [16:0] hi;
        lo = {1'b0, s[15:0]} + {9'd0, b};
        if (lo >= ADLER_MOD) lo = lo - ADLER_MOD;
        hi = {1'b0, s[31:16]} + lo;
        if (hi >= ADLER_MOD) hi = hi - ADLER_MOD;
        return {hi[15:0], lo[15:0]};
    endfunction

    task automatic finish_block();
        ph        = last_block ? PH_TRAILER : PH_BLKHDR;
        field_idx = '0;
        trailer   = '0;
    endtask

    // errors leave the state as it was
    task automatic inflate_byte(input logic [7:0] b);
        inflate_word_t w;
        logic [15:0]   nlen;
        logic [31:0]   acc;
        w.data_valid = 1'b0;
        w.data_byte  = 8'h00;
        w.status     = ST_OK;
        case (ph)
            PH_CMF: begin
                if (b[3:0] != CM_DEFLATE) w.status = ST_METHOD;
                else if (b[7:4] > CINFO_MAX) w.status = ST_WINDOW;
                else begin
                    cmf_byte = b;
                    adler    = 32'd1;
                    ph       = PH_FLG;
                end
            end
            PH_FLG: begin
                if (({cmf_byte, b} % 16'd31) != 16'd0) w.status = ST_FCHECK;
                else if (b[FDICT_BIT]) w.status = ST_DICT;
                else ph = PH_BLKHDR;
            end
            PH_BLKHDR: begin
                if (b[2:1] != 2'b00) w.status = ST_BTYPE;
                else begin
                    last_block = b[0];
                    field_idx  = '0;
                    blk_len    = '0;
                    nlen_low   = '0;
                    copied     = '0;
                    ph         = PH_LEN;
                end
            end
            PH_LEN: begin
                if (field_idx != 2'd3) begin
                    case (field_idx)
                        2'd0: blk_len = {8'h00, b};
                        2'd1: blk_len[15:8] = b;
                        default: nlen_low = b;
                    endcase
                    field_idx = field_idx + 2'd1;
                end else begin
                    nlen = {b, nlen_low};
                    if ((~nlen) != blk_len) w.status = ST_NLEN;
                    else begin
                        field_idx = '0;
                        copied    = '0;
                        if (blk_len == 16'd0) finish_block();
                        else ph = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                w.data_valid = 1'b1;
                w.data_byte  = b;
                adler        = adler_next(adler, b);
                copied       = copied + 16'd1;
                if (copied >= blk_len) finish_block();
            end
            PH_TRAILER: begin
                acc = {trailer[23:0], b};
                if (field_idx != 2'd3) begin
                    trailer   = acc;
                    field_idx = field_idx + 2'd1;
                end else if (acc != adler) w.status = ST_CHECKSUM;
                else begin
                    trailer  = acc;
                    ph       = PH_END;
                    w.status = ST_DONE;
                end
            end
            default: w.status = ST_AFTER_END;
        endcase
        inflated_words.push_back(w);
    endtask

    task automatic push_stored_block(input logic is_last, input logic [15:0] len,
                                     input fill_t fill, input bit bad_type,
                                     input bit bad_nlen);
        logic [7:0] b;
        if (bad_type)
            stream_bytes.push_back({5'($urandom), 2'($urandom_range(1, 3)), 1'($urandom)});
        stream_bytes.push_back({5'($urandom), 2'b00, is_last});
        stream_bytes.push_back(len[7:0]);
        stream_bytes.push_back(len[15:8]);
        stream_bytes.push_back(~len[7:0]);
        if (bad_nlen)
            stream_bytes.push_back((~len[15:8]) ^ 8'($urandom_range(1, 255)));
        stream_bytes.push_back(~len[15:8]);
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ONES:  b = 8'hff;
                FILL_ZEROS: b = 8'h00;
                default:    b = 8'($urandom);
            endcase
            stream_bytes.push_back(b);
            gen_adler = adler_next(gen_adler, b);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (s_tvalid && s_tready) inflate_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (stream_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stream_bytes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        inflate_word_t got;
        inflate_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.data_valid = m_tdata[0];
                got.data_byte  = m_tdata[8:1];
                got.status     = status_t'(m_tdata[12:9]);
                if (inflated_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, got valid=%0d byte=%h status=%0d",
                             $time, got.data_valid, got.data_byte, got.status);
                end else begin
                    want = inflated_words.pop_front();
                    if (got.data_valid != want.data_valid || got.data_byte != want.data_byte
                        || got.status != want.status) begin
                        mismatch_count++;
                        $display("%0t: expected dv=%0d db=%h st=%0d, got dv=%0d db=%h st=%0d",
                                 $time, want.data_valid, want.data_byte, want.status,
                                 got.data_valid, got.data_byte, got.status);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    initial begin : stimulus
        int unsigned r;
        logic [15:0] len;
        fill_t       fill;

        // header errors, then 78 9c with a dictionary and a bad check word first
        stream_bytes = '{8'h07, 8'h00, 8'hff, 8'h88, 8'hf8, 8'h78, 8'h00, 8'h20, 8'h9c};
        stream_bytes.push_back(8'h02);
        stream_bytes.push_back(8'h04);
        stream_bytes.push_back(8'h06);
        push_stored_block(1'b0, 16'd0, FILL_RANDOM, 1'b0, 1'b1);
        push_stored_block(1'b0, 16'd1, FILL_ONES, 1'b0, 1'b0);

        while (stream_bytes.size() < 1600) begin
            r = $urandom_range(0, 99);
            if (r < 5) len = 16'd0;
            else if (r < 85) len = 16'($urandom_range(1, 24));
            else len = 16'($urandom_range(25, 300));
            r = $urandom_range(0, 99);
            fill = (r < 20) ? FILL_ONES : (r < 25) ? FILL_ZEROS : FILL_RANDOM;
            push_stored_block(1'b0, len, fill, $urandom_range(0, 99) < 15,
                              $urandom_range(0, 99) < 15);
        end
        push_stored_block(1'b1, 16'($urandom_range(1, 24)), FILL_RANDOM, 1'b0, 1'b0);

        stream_bytes.push_back(gen_adler[31:24]);
        stream_bytes.push_back(gen_adler[23:16]);
        stream_bytes.push_back(gen_adler[15:8]);
        stream_bytes.push_back(gen_adler[7:0] ^ 8'($urandom_range(1, 255)));
        stream_bytes.push_back(gen_adler[7:0] ^ 8'($urandom_range(1, 255)));
        stream_bytes.push_back(gen_adler[7:0]);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hff);
        stream_bytes.push_back(8'($urandom));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (stream_bytes.size() != 0 || s_tvalid || inflated_words.size() != 0);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && inflated_words.size() == 0) begin
            $display("PASS zlib_stored_block_inflater");
        end else begin
            $display("FAIL zlib_stored_block_inflater");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL zlib_stored_block_inflater");
        $finish;
    end

endmodule
